>>> rtl/lzfd_pkg.sv
// ----------------------------------------------------------------------------
// lzfd_pkg
// Shared types and constants of the LZSS flag-byte decompressor.
// ----------------------------------------------------------------------------
package lzfd_pkg;

	localparam int WIN_DEPTH = 4096;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);
	localparam int LEN_W     = 5;
	localparam int Q_DEPTH   = 4;
	localparam int Q_AW      = $clog2(Q_DEPTH);

	localparam logic [1:0] MAX_MODE = 2'd2;
	localparam logic [3:0] FLAG_COUNT = 4'd8;

	// configuration register indexes
	localparam logic REG_OUTPUT_SIZE = 1'b0;
	localparam logic REG_MATCH_MODE  = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_done;
	} out_item_t;

	// one classified command from the parser to the copy engine
	typedef struct packed {
		logic              is_match;
		logic              restart;
		logic              done;
		logic [7:0]        lit;
		logic [WIN_AW-1:0] dist_m1;
		logic [LEN_W-1:0]  count;
	} cmd_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} bk_stat_t;

endpackage

>>> rtl/lzfd_front.sv
// ----------------------------------------------------------------------------
// lzfd_front
// Parser: tracks flag bits, token bytes and the remaining output count, and
// turns each literal or complete token into one command.
// ----------------------------------------------------------------------------
module lzfd_front import lzfd_pkg::*; #(
	parameter int SIZE_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  in_item_t              item,
	input  logic [SIZE_WIDTH-1:0] output_size,
	input  logic [1:0]            match_mode,
	output logic                  push,
	output cmd_t                  cmd
);

	localparam logic [1:0] PH_FLAG  = 2'd0;
	localparam logic [1:0] PH_ITEM  = 2'd1;
	localparam logic [1:0] PH_TOKHI = 2'd2;

	logic [1:0]            phase_q, phase_e, phase_d;
	logic [7:0]            flag_q, flag_e, flag_d;
	logic [3:0]            left_q, left_e, left_d, left_dec;
	logic [7:0]            tok_q, tok_e, tok_d;
	logic [SIZE_WIDTH-1:0] rem_q, rem_e, rem_d;
	logic                  restart_q, restart_e;
	logic [1:0]            mode_c;
	logic [LEN_W-1:0]      len, n;
	logic [SIZE_WIDTH-1:0] len_w, n_w;
	logic                  push_c;

	always_comb begin
		phase_e   = item.stream_start ? PH_FLAG : phase_q;
		flag_e    = item.stream_start ? 8'd0 : flag_q;
		left_e    = item.stream_start ? 4'd0 : left_q;
		tok_e     = item.stream_start ? 8'd0 : tok_q;
		rem_e     = item.stream_start ? output_size : rem_q;
		restart_e = item.stream_start | restart_q;

		mode_c   = (match_mode > MAX_MODE) ? MAX_MODE : match_mode;
		len      = LEN_W'(tok_e[3:0]) + LEN_W'(mode_c) + LEN_W'(1);
		len_w    = SIZE_WIDTH'(len);
		n        = (rem_e < len_w) ? rem_e[LEN_W-1:0] : len;
		n_w      = SIZE_WIDTH'(n);
		left_dec = left_e - 4'd1;

		phase_d = phase_e;
		flag_d  = flag_e;
		left_d  = left_e;
		tok_d   = tok_e;
		rem_d   = rem_e;
		push_c  = 1'b0;

		cmd.is_match = 1'b0;
		cmd.restart  = restart_e;
		cmd.done     = 1'b0;
		cmd.lit      = item.in_byte;
		cmd.dist_m1  = {item.in_byte, tok_e[7:4]};
		cmd.count    = n;

		// a finished stream swallows every byte
		if (rem_e != '0) begin
			unique case (phase_e)
				PH_ITEM: begin
					if (flag_e[0]) begin
						push_c   = 1'b1;
						cmd.done = (rem_e == SIZE_WIDTH'(1));
						rem_d    = rem_e - SIZE_WIDTH'(1);
						flag_d   = flag_e >> 1;
						left_d   = left_dec;
						phase_d  = (left_dec != 4'd0) ? PH_ITEM : PH_FLAG;
					end else begin
						tok_d   = item.in_byte;
						phase_d = PH_TOKHI;
					end
				end
				PH_TOKHI: begin
					push_c       = 1'b1;
					cmd.is_match = 1'b1;
					cmd.done     = (rem_e == n_w);
					rem_d        = rem_e - n_w;
					flag_d       = flag_e >> 1;
					left_d       = left_dec;
					phase_d      = (left_dec != 4'd0) ? PH_ITEM : PH_FLAG;
				end
				default: begin
					flag_d  = item.in_byte;
					left_d  = FLAG_COUNT;
					phase_d = PH_ITEM;
				end
			endcase
		end
	end

	assign push = take & push_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FLAG;
			flag_q    <= '0;
			left_q    <= '0;
			tok_q     <= '0;
			rem_q     <= SIZE_WIDTH'(1);
			restart_q <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_d;
			flag_q    <= flag_d;
			left_q    <= left_d;
			tok_q     <= tok_d;
			rem_q     <= rem_d;
			// hold a pending restart until a command carries it
			restart_q <= push_c ? 1'b0 : restart_e;
		end
	end

endmodule

>>> rtl/lzfd_queue.sv
// ----------------------------------------------------------------------------
// lzfd_queue
// Short command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzfd_queue import lzfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic space,
	output logic head_valid,
	output cmd_t head
);

	cmd_t            slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign space      = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (Q_AW+1)'(1);
				2'b01:   count_q <= count_q - (Q_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/lzfd_back.sv
// ----------------------------------------------------------------------------
// lzfd_back
// Copy engine: writes literals into the history window and replays matches
// from it into the output register, one byte per cycle while it has room.
// ----------------------------------------------------------------------------
module lzfd_back import lzfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head,
	output bk_stat_t  stat,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic [7:0]        mem [WIN_DEPTH];
	logic [7:0]        rdata_q;
	logic              busy_q, done_q, fwd_q, out_valid_q;
	logic [WIN_AW-1:0] wp_q, src_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [7:0]        fwd_data_q;
	out_item_t         out_q;

	logic              adv, lit_go, mat_go, run_go, last_run, we, re, emit;
	logic [WIN_AW-1:0] wp_e, src0, waddr, raddr;
	logic [7:0]        byte_v, wdata;
	out_item_t         emit_item;

	always_comb begin
		adv      = !out_valid_q || out_ready;
		wp_e     = head.restart ? '0 : wp_q;
		byte_v   = fwd_q ? fwd_data_q : rdata_q;
		last_run = (cnt_q == LEN_W'(1));
		lit_go   = !busy_q && head_valid && !head.is_match && adv;
		mat_go   = !busy_q && head_valid && head.is_match;
		run_go   = busy_q && adv;
		src0     = wp_e - head.dist_m1 - WIN_AW'(1);

		we    = lit_go | run_go;
		waddr = lit_go ? wp_e : wp_q;
		wdata = lit_go ? head.lit : byte_v;
		re    = mat_go | (run_go && !last_run);
		raddr = mat_go ? src0 : src_q;

		emit = lit_go | run_go;
		if (lit_go) begin
			emit_item.out_byte    = head.lit;
			emit_item.run_last    = 1'b1;
			emit_item.stream_done = head.done;
		end else begin
			emit_item.out_byte    = byte_v;
			emit_item.run_last    = last_run;
			emit_item.stream_done = done_q & last_run;
		end

		stat.pop  = lit_go | mat_go;
		stat.busy = busy_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (run_go) begin
			fwd_data_q <= byte_v;
		end
		if (emit) begin
			out_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			fwd_q       <= 1'b0;
			wp_q        <= '0;
			src_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (lit_go) begin
				wp_q <= wp_e + WIN_AW'(1);
			end
			if (mat_go) begin
				busy_q <= 1'b1;
				wp_q   <= wp_e;
				src_q  <= src0 + WIN_AW'(1);
				cnt_q  <= head.count;
				done_q <= head.done;
				fwd_q  <= 1'b0;
			end
			if (run_go) begin
				wp_q  <= wp_q + WIN_AW'(1);
				src_q <= src_q + WIN_AW'(1);
				cnt_q <= cnt_q - LEN_W'(1);
				// source byte is the one being written this cycle: bypass the array
				fwd_q <= (src_q == wp_q);
				if (last_run) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> rtl/lzss_flag_byte_decompressor_unit.sv
// ----------------------------------------------------------------------------
// lzss_flag_byte_decompressor_unit
// LZSS decompressor with flag bytes and a 4096-byte history window.
// ----------------------------------------------------------------------------
//   channel   signals                          direction
//   in        in_valid / in_ready / in_item    compressed bytes in
//   out       out_valid / out_ready / out_item decompressed bytes out
//   cfg       cfg_wr_en / cfg_index / cfg_data register writes
//
// The parser takes one byte per cycle while its 4-entry command queue has room.
// A literal passes through the copy engine as one write and one output;
// a match first issues its history read, then yields its bytes (up to 18).
// The history array read port sets the match rate of one byte per cycle.
// Reset clears all control state; the history contents stay undefined.
// A stalled output register holds the copy engine; the parser runs on until
// the queue fills.
// ----------------------------------------------------------------------------
module lzss_flag_byte_decompressor_unit import lzfd_pkg::*; #(
	parameter int SIZE_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [SIZE_WIDTH-1:0] cfg_data
);

	logic [SIZE_WIDTH-1:0] output_size_q;
	logic [1:0]            match_mode_q;
	logic                  take, push, space, head_valid;
	cmd_t                  push_cmd, head;
	bk_stat_t              bk_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_size_q <= SIZE_WIDTH'(1);
			match_mode_q  <= 2'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_OUTPUT_SIZE: output_size_q <= cfg_data;
				REG_MATCH_MODE:  match_mode_q  <= cfg_data[1:0];
				default:         output_size_q <= output_size_q;
			endcase
		end
	end

	assign in_ready = space;
	assign take     = in_valid & in_ready;

	lzfd_front #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (in_item),
		.output_size(output_size_q),
		.match_mode (match_mode_q),
		.push       (push),
		.cmd        (push_cmd)
	);

	lzfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (bk_stat.pop),
		.space     (space),
		.head_valid(head_valid),
		.head      (head)
	);

	lzfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.stat      (bk_stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.stream_done |-> out_item.run_last)
		else $error("stream_done without run_last");

	a_match_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop && head.is_match |=> bk_stat.busy)
		else $error("copy engine not busy after taking a match");

	a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.busy |-> !bk_stat.pop)
		else $error("command popped while a match is running");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |-> head_valid)
		else $error("pop from an empty command queue");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LZSS flag-byte decompressor. A short table of
// hand-built streams covers literals, minimum and maximum matches, the full
// window distance, ignored bytes and the register extremes. Random streams
// follow: well-formed flag groups with random literals and tokens whose
// history reads are always already written, with restarts and trailing
// noise mixed in. A behavioral decoder predicts every output byte and each
// output request is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
	import lzfd_pkg::*;

	localparam int DRAIN_CYCLES    = 32;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 23;
	localparam int SIDE_IN         = 0;
	localparam int SIDE_OUT        = 1;

	typedef enum logic [1:0] {WANT_FLAG, WANT_ITEM, WANT_TOKEN_HI} parse_at_t;

	typedef struct packed {
		logic        cfg;
		logic [23:0] size;
		logic [1:0]  mode;
		logic [7:0]  in_byte;
		logic        start;
		logic        typed;
		logic [7:0]  want_byte;
		logic        want_last;
		logic        want_done;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = REG_OUTPUT_SIZE;
	logic [23:0] cfg_data = '0;

	// decoder state mirrored by the bench
	logic [23:0] cfg_size;
	logic [1:0]  cfg_mode;
	parse_at_t   parse_at;
	logic [7:0]  flag_reg;
	logic [3:0]  flags_todo;
	logic [7:0]  tok_lo;
	logic [23:0] bytes_left;
	logic [11:0] wr_pos;
	logic [7:0]  window [0:WIN_DEPTH-1];
	bit          window_set [0:WIN_DEPTH-1];
	out_item_t   decoded_due [$];

	logic [15:0]   planned_tok;
	int            calm_left [2];
	int            errors = 0;
	int            quiet = 0;
	int            out_wait = 0;
	directed_row_t plan [0:18];

	lzss_flag_byte_decompressor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic directed_row_t row(bit cfg, int size, int mode, int b, bit start,
			bit typed, int wb, bit wl, bit wd);
		directed_row_t r;
		r.cfg       = cfg;
		r.size      = size[23:0];
		r.mode      = mode[1:0];
		r.in_byte   = b[7:0];
		r.start     = start;
		r.typed     = typed;
		r.want_byte = wb[7:0];
		r.want_last = wl;
		r.want_done = wd;
		return r;
	endfunction

	// mostly a random idle gap, with occasional stretches of back-to-back requests
	function automatic int draw_gap(input int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm_left[side] = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 5);
	endfunction

	function automatic int match_length(input logic [3:0] nib);
		int mode;
		mode = (cfg_mode > MAX_MODE) ? MAX_MODE : cfg_mode;
		return nib + mode + 1;
	endfunction

	// a token is usable only if every byte it copies from before the current
	// write position has been written since reset
	function automatic bit token_safe(input logic [15:0] tok, input logic [11:0] wp,
			input logic [23:0] left);
		int len;
		int n;
		int span;
		logic [11:0] src;
		logic [11:0] pos;
		len  = match_length(tok[3:0]);
		n    = (len > left) ? left : len;
		span = tok[15:4] + 1;
		src  = wp - tok[15:4] - 12'd1;
		for (int i = 0; i < n && i < span; i++) begin
			pos = src + 12'(i);
			if (!window_set[pos])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [15:0] pick_token(input logic [11:0] wp, input logic [23:0] left);
		logic [15:0] tok;
		logic [11:0] dist_m1;
		for (int tries = 0; tries < 16; tries++) begin
			case ($urandom_range(0, 3))
				0: dist_m1 = 12'($urandom_range(0, 3));
				1: dist_m1 = 12'($urandom_range(0, 31));
				2: dist_m1 = 12'($urandom_range(0, 255));
				default: dist_m1 = 12'($urandom_range(0, WIN_DEPTH - 1));
			endcase
			tok = {dist_m1, 4'($urandom_range(0, 15))};
			if (token_safe(tok, wp, left))
				return tok;
		end
		// distance one always reads the last byte written
		return {12'd0, 4'($urandom_range(0, 15))};
	endfunction

	task automatic append_byte(input logic [7:0] b, input bit last, input bit queue_it);
		out_item_t r;
		window[wr_pos]     = b;
		window_set[wr_pos] = 1'b1;
		wr_pos             = wr_pos + 12'd1;
		bytes_left         = bytes_left - 24'd1;
		r.out_byte    = b;
		r.run_last    = last;
		r.stream_done = (bytes_left == 24'd0);
		if (queue_it)
			decoded_due.push_back(r);
	endtask

	task automatic next_flag_bit();
		flag_reg   = flag_reg >> 1;
		flags_todo = flags_todo - 4'd1;
		parse_at   = (flags_todo != 4'd0) ? WANT_ITEM : WANT_FLAG;
	endtask

	task automatic decode_step(input in_item_t it, input bit queue_it, output bit used);
		logic [15:0] tok;
		logic [11:0] src;
		int len;
		int n;
		if (it.stream_start) begin
			bytes_left = cfg_size;
			parse_at   = WANT_FLAG;
			flag_reg   = 8'd0;
			flags_todo = 4'd0;
			tok_lo     = 8'd0;
			wr_pos     = 12'd0;
		end
		used = (bytes_left != 24'd0);
		if (!used)
			return;
		case (parse_at)
			WANT_ITEM: begin
				if (flag_reg[0]) begin
					append_byte(it.in_byte, 1'b1, queue_it);
					next_flag_bit();
				end else begin
					tok_lo   = it.in_byte;
					parse_at = WANT_TOKEN_HI;
				end
			end
			WANT_TOKEN_HI: begin
				tok = {it.in_byte, tok_lo};
				len = match_length(tok[3:0]);
				n   = (len > bytes_left) ? bytes_left : len;
				src = wr_pos - tok[15:4] - 12'd1;
				for (int i = 0; i < n; i++) begin
					append_byte(window[src], i == n - 1, queue_it);
					src = src + 12'd1;
				end
				next_flag_bit();
			end
			default: begin
				flag_reg   = it.in_byte;
				flags_todo = FLAG_COUNT;
				parse_at   = WANT_ITEM;
			end
		endcase
	endtask

	task automatic next_random_item(input bit force_start, output in_item_t it);
		bit start;
		parse_at_t at;
		logic [11:0] wp;
		logic [11:0] prev;
		logic [23:0] left;
		start = force_start || $urandom_range(0, 39) == 0 ||
			(bytes_left == 24'd0 && $urandom_range(0, 7) != 0);
		at   = start ? WANT_FLAG : parse_at;
		wp   = start ? 12'd0 : wr_pos;
		left = start ? cfg_size : bytes_left;
		it.stream_start = start;
		it.in_byte      = 8'($urandom);
		if (left != 24'd0) begin
			case (at)
				WANT_ITEM: begin
					if (!flag_reg[0]) begin
						planned_tok = pick_token(wp, left);
						it.in_byte  = planned_tok[7:0];
					end
				end
				WANT_TOKEN_HI: it.in_byte = planned_tok[15:8];
				default: begin
					// open with a literal when there is nothing behind to copy
					prev = wp - 12'd1;
					if (!window_set[prev])
						it.in_byte[0] = 1'b1;
				end
			endcase
		end
	endtask

	task automatic send_request(input in_item_t it, input bit typed, input out_item_t want,
			output bit used);
		int gap;
		gap = draw_gap(SIDE_IN);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_step(it, !typed, used);
		if (typed)
			decoded_due.push_back(want);
	endtask

	// drop the request line, wait for all output and let the pipeline drain
	task automatic settle();
		in_valid <= 1'b0;
		while (decoded_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [23:0] size, input logic [1:0] mode);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_OUTPUT_SIZE;
		cfg_data  <= size;
		@(posedge clk);
		cfg_index <= REG_MATCH_MODE;
		cfg_data  <= {22'd0, mode};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_size = size;
		cfg_mode = mode;
	endtask

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 50)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_due.size() == 0) begin
				note_error($sformatf("output byte %02h with nothing pending", out_item.out_byte));
			end else begin
				want = decoded_due.pop_front();
				if (out_item.out_byte !== want.out_byte)
					note_error($sformatf("out_byte %02h, expected %02h",
						out_item.out_byte, want.out_byte));
				if (out_item.run_last !== want.run_last)
					note_error($sformatf("run_last %b, expected %b",
						out_item.run_last, want.run_last));
				if (out_item.stream_done !== want.stream_done)
					note_error($sformatf("stream_done %b, expected %b",
						out_item.stream_done, want.stream_done));
			end
			out_wait = draw_gap(SIDE_OUT);
		end else if (out_wait > 0) begin
			out_wait--;
		end
		out_ready <= (out_wait == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		in_item_t  it;
		out_item_t want;
		bit        used;
		bit        first;
		int        counted;
		logic [23:0] size;

		// reset state: one byte per stream, mode one
		cfg_size   = 24'd1;
		cfg_mode   = 2'd1;
		parse_at   = WANT_FLAG;
		flag_reg   = 8'd0;
		flags_todo = 4'd0;
		tok_lo     = 8'd0;
		bytes_left = 24'd1;
		wr_pos     = 12'd0;

		//              cfg  size        mode byte   st typed want   last done
		plan[0]  = row(0, 0,          0, 8'hFF, 0, 0, 8'h00, 0, 0);
		plan[1]  = row(0, 0,          0, 8'h00, 0, 1, 8'h00, 1, 1);
		plan[2]  = row(0, 0,          0, 8'hFF, 0, 0, 8'h00, 0, 0); // after done
		plan[3]  = row(1, 20,         0, 8'hD3, 1, 0, 8'h00, 0, 0); // mode zero
		plan[4]  = row(0, 0,          0, 8'hFF, 0, 1, 8'hFF, 1, 0);
		plan[5]  = row(0, 0,          0, 8'h80, 0, 1, 8'h80, 1, 0);
		plan[6]  = row(0, 0,          0, 8'h00, 0, 0, 8'h00, 0, 0);
		plan[7]  = row(0, 0,          0, 8'h00, 0, 0, 8'h00, 0, 0); // one byte, dist 1
		plan[8]  = row(0, 0,          0, 8'h1F, 0, 0, 8'h00, 0, 0);
		plan[9]  = row(0, 0,          0, 8'h00, 0, 0, 8'h00, 0, 0); // overlapping copy
		plan[10] = row(0, 0,          0, 8'h55, 0, 1, 8'h55, 1, 1);
		plan[11] = row(0, 0,          0, 8'h12, 0, 0, 8'h00, 0, 0);
		plan[12] = row(1, 24'hFFFFFF, 3, 8'h00, 1, 0, 8'h00, 0, 0); // mode three
		plan[13] = row(0, 0,          0, 8'hFF, 0, 0, 8'h00, 0, 0);
		plan[14] = row(0, 0,          0, 8'hFF, 0, 0, 8'h00, 0, 0); // 18 bytes, full window
		plan[15] = row(0, 0,          0, 8'h00, 0, 0, 8'h00, 0, 0);
		plan[16] = row(0, 0,          0, 8'h00, 0, 0, 8'h00, 0, 0);
		plan[17] = row(1, 0,          2, 8'hFF, 1, 0, 8'h00, 0, 0); // empty stream
		plan[18] = row(0, 0,          0, 8'h42, 0, 0, 8'h00, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < $size(plan); k++) begin
			if (plan[k].cfg) begin
				settle();
				write_config(plan[k].size, plan[k].mode);
			end
			it.in_byte       = plan[k].in_byte;
			it.stream_start  = plan[k].start;
			want.out_byte    = plan[k].want_byte;
			want.run_last    = plan[k].want_last;
			want.stream_done = plan[k].want_done;
			send_request(it, plan[k].typed, want, used);
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			case (p)
				0: size = 24'd1;
				1: size = 24'd2;
				default: size = 24'($urandom_range(8, 80));
			endcase
			write_config(size, 2'($urandom_range(0, 3)));
			counted = 0;
			first   = 1'b1;
			while (counted < ITEMS_PER_PHASE) begin
				next_random_item(first, it);
				first = 1'b0;
				send_request(it, 1'b0, want, used);
				if (used)
					counted++;
			end
		end

		settle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
